// ===== sv/assert_macros.svh =====
// Assertion helpers, clocked on clk_i and disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge.
`define BGD_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("bgd assertion failed");

// Antecedent in this cycle implies consequent in the next.
`define BGD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bgd assertion failed");

`endif

// ===== sv/bgd_pkg.sv =====
package bgd_pkg;

  localparam int TIME_BITS_DEF  = 16;
  localparam int COUNT_BITS_DEF = 8;
  localparam int CFG_W          = 16;
  localparam int TMR_W          = 16;
  localparam int MAX_EV         = 5;
  localparam int EV_CNT_W       = 3;

  localparam logic [CFG_W-1:0] HOLD_FLOOR = 16'd50;

  localparam logic             ACTIVE_LEVEL_RST = 1'b0;
  localparam logic [CFG_W-1:0] DBCLICK_RST      = 16'd300;
  localparam logic [CFG_W-1:0] IDLE_RST         = 16'd1000;
  localparam logic [CFG_W-1:0] LONG_RST         = 16'd1000;
  localparam logic [CFG_W-1:0] HOLD_CHECK_RST   = 16'd50;
  localparam logic [CFG_W-1:0] HOLD_A_RST       = 16'd0;
  localparam logic [CFG_W-1:0] HOLD_B_RST       = 16'd0;

  typedef enum logic [2:0] {
    REG_ACTIVE_LEVEL = 3'd0,
    REG_DBCLICK      = 3'd1,
    REG_IDLE         = 3'd2,
    REG_LONG         = 3'd3,
    REG_HOLD_CHECK   = 3'd4,
    REG_HOLD_A       = 3'd5,
    REG_HOLD_B       = 3'd6
  } reg_idx_e;

  typedef enum logic [2:0] {
    EV_PRESS   = 3'd0,
    EV_RELEASE = 3'd1,
    EV_CHANGE  = 3'd2,
    EV_CLICK   = 3'd3,
    EV_LONG    = 3'd4,
    EV_HOLDA   = 3'd5,
    EV_HOLDB   = 3'd6,
    EV_IDLE    = 3'd7
  } ev_code_e;

  typedef struct packed {
    logic             active_level;
    logic [CFG_W-1:0] dbclick_ms;
    logic [CFG_W-1:0] idle_ms;
    logic [CFG_W-1:0] long_ms;
    logic [CFG_W-1:0] hold_check_ms;
    logic [CFG_W-1:0] hold_a_ms;
    logic [CFG_W-1:0] hold_b_ms;
  } cfg_t;

  typedef struct packed {
    ev_code_e    code;
    logic [7:0]  count;
    logic [15:0] held;
  } ev_t;

endpackage

// ===== sv/bgd_core.sv =====
`include "assert_macros.svh"

// Per-tick state update; builds the ordered event list of one tick.
module bgd_core #(
  parameter int TIME_BITS  = bgd_pkg::TIME_BITS_DEF,
  parameter int COUNT_BITS = bgd_pkg::COUNT_BITS_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  bgd_pkg::cfg_t                             cfg_i,
  input  logic                                      tick_i,
  input  logic                                      pin_level_i,
  output bgd_pkg::ev_t [bgd_pkg::MAX_EV-1:0]        ev_o,
  output logic [bgd_pkg::EV_CNT_W-1:0]              ev_cnt_o
);
  import bgd_pkg::*;

  typedef enum logic [1:0] {
    TM_NONE  = 2'd0,
    TM_HOLD  = 2'd1,
    TM_CLICK = 2'd2,
    TM_IDLE  = 2'd3
  } tmr_mode_e;

  localparam int CW   = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;
  localparam int CNTW = (COUNT_BITS > 8) ? COUNT_BITS : 8;
  localparam logic [TIME_BITS-1:0]  TIME_MAX  = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam int NCAND = 8;

  logic                  prev_q, prev_d;
  logic [COUNT_BITS-1:0] clicks_q, clicks_d;
  logic [TMR_W-1:0]      tl_q, tl_d;
  tmr_mode_e             mode_q, mode_d;
  logic [TIME_BITS-1:0]  sp_q, sp_d, sr_q, sr_d, plen_q, plen_d;
  logic                  pv_q, pv_d, rv_q, rv_d;
  logic [2:0]            fl_q, fl_d;

  logic [TMR_W-1:0] hold_per, idle_dly, idle_len, db_len;
  logic [15:0]      held_sat;
  logic [7:0]       cnt_sat;
  logic             expire;
  logic             cand_v [NCAND];
  ev_t              cand   [NCAND];
  ev_t              ev_d   [MAX_EV];
  logic [3:0]       n;

  assign hold_per = (cfg_i.hold_check_ms < HOLD_FLOOR) ? HOLD_FLOOR : cfg_i.hold_check_ms;
  assign idle_dly = (cfg_i.idle_ms > cfg_i.dbclick_ms) ?
                    cfg_i.idle_ms - cfg_i.dbclick_ms : cfg_i.idle_ms;
  assign idle_len = (idle_dly == '0) ? TMR_W'(1) : idle_dly;
  assign db_len   = (cfg_i.dbclick_ms == '0) ? TMR_W'(1) : cfg_i.dbclick_ms;

  always_comb begin
    prev_d   = prev_q;
    clicks_d = clicks_q;
    tl_d     = tl_q;
    mode_d   = mode_q;
    sp_d     = sp_q;
    sr_d     = sr_q;
    plen_d   = plen_q;
    pv_d     = pv_q;
    rv_d     = rv_q;
    fl_d     = fl_q;
    expire   = 1'b0;
    for (int i = 0; i < NCAND; i++) begin
      cand_v[i] = 1'b0;
      cand[i]   = '{code: EV_CHANGE, count: 8'd0, held: 16'd0};
    end

    if (pv_q && sp_q != TIME_MAX) sp_d = sp_q + TIME_BITS'(1);
    if (rv_q && sr_q != TIME_MAX) sr_d = sr_q + TIME_BITS'(1);

    held_sat = (CW'(sp_d) > CW'(16'hFFFF)) ? 16'hFFFF : 16'(sp_d);
    cnt_sat  = (CNTW'(clicks_q) > CNTW'(8'hFF)) ? 8'hFF : 8'(clicks_q);

    // timer: counts down, runs its action on reaching zero
    if (mode_q != TM_NONE) begin
      tl_d   = (tl_q != '0) ? tl_q - TMR_W'(1) : '0;
      expire = (tl_d == '0);
    end
    if (expire) begin
      case (mode_q)
        TM_HOLD: begin
          if (pv_q) begin
            if (!fl_q[0] && CW'(sp_d) >= CW'(cfg_i.long_ms)) begin
              fl_d[0]   = 1'b1;
              cand_v[0] = 1'b1;
              cand[0]   = '{code: EV_LONG, count: 8'd0, held: held_sat};
            end
            if (!fl_q[1] && cfg_i.hold_a_ms != '0 && CW'(sp_d) >= CW'(cfg_i.hold_a_ms)) begin
              fl_d[1]   = 1'b1;
              cand_v[1] = 1'b1;
              cand[1]   = '{code: EV_HOLDA, count: 8'd0, held: held_sat};
            end
            if (!fl_q[2] && cfg_i.hold_b_ms != '0 && CW'(sp_d) >= CW'(cfg_i.hold_b_ms)) begin
              fl_d[2]   = 1'b1;
              cand_v[2] = 1'b1;
              cand[2]   = '{code: EV_HOLDB, count: 8'd0, held: held_sat};
            end
          end
          tl_d = hold_per;
        end
        TM_CLICK: begin
          if (clicks_q != '0) begin
            if (CW'(plen_q) < CW'(cfg_i.long_ms)) begin
              cand_v[3] = 1'b1;
              cand[3]   = '{code: EV_CLICK, count: cnt_sat, held: 16'd0};
            end
            clicks_d = '0;
          end
          mode_d = TM_IDLE;
          tl_d   = idle_len;
        end
        TM_IDLE: begin
          if (rv_q) begin
            cand_v[4] = 1'b1;
            cand[4]   = '{code: EV_IDLE, count: 8'd0, held: 16'd0};
            cand_v[5] = 1'b1;
            fl_d      = '0;
            rv_d      = 1'b0;
            pv_d      = 1'b0;
            clicks_d  = '0;
          end
          mode_d = TM_NONE;
        end
        default: ;
      endcase
    end

    // level change after the timer action
    if (pin_level_i != prev_q) begin
      prev_d    = pin_level_i;
      cand_v[6] = 1'b1;
      cand_v[7] = 1'b1;
      if (pin_level_i == cfg_i.active_level) begin
        cand[6] = '{code: EV_PRESS, count: 8'd0, held: 16'd0};
        sp_d    = '0;
        pv_d    = 1'b1;
        if (clicks_d == '0) clicks_d = COUNT_BITS'(1);
        if (rv_d && CW'(sr_d) < CW'(cfg_i.dbclick_ms) && clicks_d != COUNT_MAX)
          clicks_d = clicks_d + COUNT_BITS'(1);
        mode_d = TM_HOLD;
        tl_d   = hold_per;
      end else begin
        cand[6] = '{code: EV_RELEASE, count: 8'd0, held: 16'd0};
        plen_d  = pv_d ? sp_d : TIME_MAX;
        sr_d    = '0;
        rv_d    = 1'b1;
        mode_d  = TM_CLICK;
        tl_d    = db_len;
      end
    end

    // pack the valid candidates in order
    n = '0;
    for (int i = 0; i < MAX_EV; i++) ev_d[i] = '{code: EV_CHANGE, count: 8'd0, held: 16'd0};
    for (int i = 0; i < NCAND; i++) begin
      if (cand_v[i]) begin
        if (n < 4'(MAX_EV)) ev_d[n[EV_CNT_W-1:0]] = cand[i];
        n = n + 4'd1;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_EV; i++) ev_o[i] = ev_d[i];
  end
  assign ev_cnt_o = EV_CNT_W'(n);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= ~ACTIVE_LEVEL_RST;
      clicks_q <= '0;
      tl_q     <= '0;
      mode_q   <= TM_NONE;
      sp_q     <= '0;
      sr_q     <= TIME_MAX;
      plen_q   <= '0;
      pv_q     <= 1'b0;
      rv_q     <= 1'b0;
      fl_q     <= '0;
    end else if (tick_i) begin
      prev_q   <= prev_d;
      clicks_q <= clicks_d;
      tl_q     <= tl_d;
      mode_q   <= mode_d;
      sp_q     <= sp_d;
      sr_q     <= sr_d;
      plen_q   <= plen_d;
      pv_q     <= pv_d;
      rv_q     <= rv_d;
      fl_q     <= fl_d;
    end
  end

  `BGD_ASSERT(a_stopped_timer_clear, mode_q != TM_NONE || tl_q == '0)
  `BGD_ASSERT(a_clicks_need_press, clicks_q == '0 || pv_q)
  `BGD_ASSERT(a_ev_count_bound, !tick_i || n <= 4'(MAX_EV))

endmodule

// ===== sv/bgd_queue.sv =====
`include "assert_macros.svh"

// Holds one tick's events and hands them out one per cycle, while out_stall_i is low, via an output register.
module bgd_queue (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               load_i,
  input  bgd_pkg::ev_t [bgd_pkg::MAX_EV-1:0] ev_i,
  input  logic [bgd_pkg::EV_CNT_W-1:0]       ev_cnt_i,
  output logic                               busy_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output bgd_pkg::ev_t                       out_ev_o,
  output logic                               out_last_o
);
  import bgd_pkg::*;

  ev_t [MAX_EV-1:0]    slot_q;
  logic [EV_CNT_W-1:0] cnt_q;
  logic                vld_q;
  ev_t                 out_q;
  logic                last_q;
  logic                pop;

  assign pop    = (cnt_q != '0) && (!vld_q || !out_stall_i);
  assign busy_o = (cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      vld_q <= 1'b0;
    end else begin
      if (load_i) begin
        cnt_q <= ev_cnt_i;
      end else if (pop) begin
        cnt_q <= cnt_q - EV_CNT_W'(1);
      end
      if (pop) begin
        vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slot_q <= ev_i;
    end else if (pop) begin
      for (int i = 0; i < MAX_EV - 1; i++) slot_q[i] <= slot_q[i+1];
    end
    if (pop) begin
      out_q  <= slot_q[0];
      last_q <= (cnt_q == EV_CNT_W'(1));
    end
  end

  assign out_valid_o = vld_q;
  assign out_ev_o    = out_q;
  assign out_last_o  = last_q;

  `BGD_ASSERT(a_cnt_bound, cnt_q <= EV_CNT_W'(MAX_EV))
  `BGD_ASSERT(a_load_when_empty, !load_i || cnt_q == '0)
  `BGD_ASSERT_NEXT(a_last_marked, pop && cnt_q == EV_CNT_W'(1), vld_q && last_q)

endmodule

// ===== sv/button_gesture_detector.sv =====
// Button gesture detector. Each input transaction is one millisecond tick with
// the qualified pin level; it yields zero to five event transactions (pressed,
// released, state change, click with count, long, hold a, hold b, idle), the
// last one flagged by last_of_tick_o. A tick is absorbed and its events are
// loaded into a queue; they leave one per cycle from an output register while
// out_stall_i is low, and the next tick is not taken until the queue has handed
// its events to that register. in_stall_o is high while the queue still holds
// events of the previous tick. Configuration registers are written through
// cfg_we_i/cfg_idx_i/cfg_data_i by the user only while the block is idle; the
// block itself does not enforce this. Index seven is ignored.
module button_gesture_detector #(
  parameter int TIME_BITS  = bgd_pkg::TIME_BITS_DEF,
  parameter int COUNT_BITS = bgd_pkg::COUNT_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [2:0]                cfg_idx_i,
  input  logic [bgd_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      pin_level_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [2:0]                event_code_o,
  output logic [7:0]                click_count_o,
  output logic [15:0]               held_ms_o,
  output logic                      last_of_tick_o
);
  import bgd_pkg::*;

  cfg_t                cfg_q;
  logic                tick;
  logic                busy;
  ev_t [MAX_EV-1:0]    ev;
  logic [EV_CNT_W-1:0] ev_cnt;
  ev_t                 out_ev;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_level  <= ACTIVE_LEVEL_RST;
      cfg_q.dbclick_ms    <= DBCLICK_RST;
      cfg_q.idle_ms       <= IDLE_RST;
      cfg_q.long_ms       <= LONG_RST;
      cfg_q.hold_check_ms <= HOLD_CHECK_RST;
      cfg_q.hold_a_ms     <= HOLD_A_RST;
      cfg_q.hold_b_ms     <= HOLD_B_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ACTIVE_LEVEL: cfg_q.active_level  <= cfg_data_i[0];
        REG_DBCLICK:      cfg_q.dbclick_ms    <= cfg_data_i;
        REG_IDLE:         cfg_q.idle_ms       <= cfg_data_i;
        REG_LONG:         cfg_q.long_ms       <= cfg_data_i;
        REG_HOLD_CHECK:   cfg_q.hold_check_ms <= cfg_data_i;
        REG_HOLD_A:       cfg_q.hold_a_ms     <= cfg_data_i;
        REG_HOLD_B:       cfg_q.hold_b_ms     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = busy;
  assign tick       = in_valid_i && !busy;

  bgd_core #(
    .TIME_BITS  (TIME_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .tick_i      (tick),
    .pin_level_i (pin_level_i),
    .ev_o        (ev),
    .ev_cnt_o    (ev_cnt)
  );

  bgd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (tick),
    .ev_i        (ev),
    .ev_cnt_i    (ev_cnt),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_ev_o    (out_ev),
    .out_last_o  (last_of_tick_o)
  );

  assign event_code_o  = out_ev.code;
  assign click_count_o = out_ev.count;
  assign held_ms_o     = out_ev.held;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import bgd_pkg::*;

  localparam int TIME_MAX      = 65535;
  localparam int COUNT_MAX     = 255;
  localparam int SETTLE_CYCLES = 8;
  localparam int SCRIPT_LEN    = 28;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  typedef enum logic [1:0] {
    TMR_NONE,
    TMR_HOLD,
    TMR_CLICK,
    TMR_IDLE
  } tmr_mode_e;

  typedef struct {
    ev_code_e    code;
    logic [7:0]  count;
    logic [15:0] held;
    logic        last;
  } gesture_ev_t;

  // One directed tick; when typed, n events (c0 with count k0, then c1) are expected.
  typedef struct {
    logic       lvl;
    bit         typed;
    int         n;
    ev_code_e   c0;
    logic [7:0] k0;
    ev_code_e   c1;
  } script_row_t;

  logic              clk_i;
  logic              rst_ni       = 1'b0;
  logic              cfg_we_i     = 1'b0;
  logic [2:0]        cfg_idx_i    = 3'd0;
  logic [CFG_W-1:0]  cfg_data_i   = '0;
  logic              in_valid_i   = 1'b0;
  logic              in_stall_o;
  logic              pin_level_i  = 1'b1;
  logic              out_valid_o;
  logic              out_stall_i  = 1'b0;
  logic [2:0]        event_code_o;
  logic [7:0]        click_count_o;
  logic [15:0]       held_ms_o;
  logic              last_of_tick_o;

  button_gesture_detector dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .pin_level_i    (pin_level_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .event_code_o   (event_code_o),
    .click_count_o  (click_count_o),
    .held_ms_o      (held_ms_o),
    .last_of_tick_o (last_of_tick_o)
  );

  // Gesture state mirror
  cfg_t      cfg_now;
  logic      prev_lvl       = 1'b1;
  int        clicks         = 0;
  int        timer_left     = 0;
  tmr_mode_e tmr_mode       = TMR_NONE;
  int        since_press    = 0;
  int        since_release  = TIME_MAX;
  int        last_press_len = 0;
  bit        press_ok       = 1'b0;
  bit        release_ok     = 1'b0;
  logic [2:0] fired         = 3'b000;

  gesture_ev_t tick_evs[$];
  gesture_ev_t typed_evs[$];
  gesture_ev_t pending_events[$];
  bit          use_typed    = 1'b0;
  int          burst_left   = 0;
  int          mismatches   = 0;
  int          stall_cycle  = 0;
  script_row_t script [SCRIPT_LEN];

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("button_gesture_detector regression: fail");
    $finish;
  end

  function automatic int hold_period();
    return (int'(cfg_now.hold_check_ms) < int'(HOLD_FLOOR)) ? int'(HOLD_FLOOR)
                                                             : int'(cfg_now.hold_check_ms);
  endfunction

  function automatic int nonzero(int v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic cfg_t make_settings(logic act, int db, int idle, int lng,
                                         int hc, int ha, int hb);
    cfg_t s;
    s.active_level  = act;
    s.dbclick_ms    = db[15:0];
    s.idle_ms       = idle[15:0];
    s.long_ms       = lng[15:0];
    s.hold_check_ms = hc[15:0];
    s.hold_a_ms     = ha[15:0];
    s.hold_b_ms     = hb[15:0];
    return s;
  endfunction

  task automatic note_event(ev_code_e code, int cnt, int held);
    gesture_ev_t e;
    if (tick_evs.size() < MAX_EV) begin
      e.code  = code;
      e.count = (cnt > COUNT_MAX) ? 8'd255 : cnt[7:0];
      e.held  = (held > TIME_MAX) ? 16'hFFFF : held[15:0];
      e.last  = 1'b0;
      tick_evs.push_back(e);
    end
  endtask

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  // Events one millisecond tick causes: timer action first, then the edge.
  task automatic predict_tick(input logic lvl);
    int eff;
    tick_evs.delete();
    if (press_ok && since_press < TIME_MAX) since_press++;
    if (release_ok && since_release < TIME_MAX) since_release++;

    if (tmr_mode != TMR_NONE) begin
      if (timer_left > 0) timer_left--;
      if (timer_left == 0) begin
        case (tmr_mode)
          TMR_HOLD: begin
            if (press_ok) begin
              if (!fired[0] && since_press >= int'(cfg_now.long_ms)) begin
                fired[0] = 1'b1;
                note_event(EV_LONG, 0, since_press);
              end
              if (!fired[1] && cfg_now.hold_a_ms != 0 &&
                  since_press >= int'(cfg_now.hold_a_ms)) begin
                fired[1] = 1'b1;
                note_event(EV_HOLDA, 0, since_press);
              end
              if (!fired[2] && cfg_now.hold_b_ms != 0 &&
                  since_press >= int'(cfg_now.hold_b_ms)) begin
                fired[2] = 1'b1;
                note_event(EV_HOLDB, 0, since_press);
              end
            end
            timer_left = hold_period();
          end
          TMR_CLICK: begin
            if (clicks != 0) begin
              // a long last press swallows the click
              if (last_press_len < int'(cfg_now.long_ms)) note_event(EV_CLICK, clicks, 0);
              clicks = 0;
            end
            eff = int'(cfg_now.idle_ms);
            if (eff <= int'(cfg_now.dbclick_ms)) eff += int'(cfg_now.dbclick_ms);
            tmr_mode   = TMR_IDLE;
            timer_left = nonzero(eff - int'(cfg_now.dbclick_ms));
          end
          TMR_IDLE: begin
            if (release_ok) begin
              note_event(EV_IDLE, 0, 0);
              note_event(EV_CHANGE, 0, 0);
              fired      = 3'b000;
              release_ok = 1'b0;
              press_ok   = 1'b0;
              clicks     = 0;
            end
            tmr_mode = TMR_NONE;
          end
          default: ;
        endcase
      end
    end

    if (lvl !== prev_lvl) begin
      prev_lvl = lvl;
      if (lvl === cfg_now.active_level) begin
        since_press = 0;
        press_ok    = 1'b1;
        if (clicks == 0) clicks = 1;
        if (release_ok && since_release < int'(cfg_now.dbclick_ms) && clicks < COUNT_MAX)
          clicks++;
        tmr_mode   = TMR_HOLD;
        timer_left = hold_period();
        note_event(EV_PRESS, 0, 0);
      end else begin
        last_press_len = press_ok ? since_press : TIME_MAX;
        since_release  = 0;
        release_ok     = 1'b1;
        tmr_mode       = TMR_CLICK;
        timer_left     = nonzero(int'(cfg_now.dbclick_ms));
        note_event(EV_RELEASE, 0, 0);
      end
      note_event(EV_CHANGE, 0, 0);
    end

    if (tick_evs.size() > 0) tick_evs[tick_evs.size() - 1].last = 1'b1;
  endtask

  // Sender: bursts of random length, random gaps between them.
  task automatic push_tick(input logic lvl);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    pin_level_i <= lvl;
    do @(posedge clk_i); while (in_stall_o);
    predict_tick(lvl);
    if (use_typed) tick_evs = typed_evs;
    foreach (tick_evs[i]) pending_events.push_back(tick_evs[i]);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic load_settings(cfg_t s);
    logic [CFG_W-1:0] junk;
    junk = CFG_W'($urandom);
    write_reg(REG_UNUSED, ~junk);
    // upper bits of the level register are don't-care
    write_reg(REG_ACTIVE_LEVEL, {junk[CFG_W-1:1], s.active_level});
    write_reg(REG_DBCLICK,      s.dbclick_ms);
    write_reg(REG_IDLE,         s.idle_ms);
    write_reg(REG_LONG,         s.long_ms);
    write_reg(REG_HOLD_CHECK,   s.hold_check_ms);
    write_reg(REG_HOLD_A,       s.hold_a_ms);
    write_reg(REG_HOLD_B,       s.hold_b_ms);
    cfg_we_i <= 1'b0;
    cfg_now = s;
  endtask

  // Well-formed press/release pairs with random lengths, plus some noise ticks.
  task automatic run_gestures(int n_ticks);
    int   sent;
    int   plen;
    int   rlen;
    int   r;
    logic act;
    sent = 0;
    act  = cfg_now.active_level;
    while (sent < n_ticks) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        push_tick(1'($urandom_range(0, 1)));
        sent++;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65)      plen = $urandom_range(1, 4);
        else if (r < 85) plen = $urandom_range(5, 20);
        else             plen = ($urandom_range(0, 2) == 0) ? 50 : $urandom_range(45, 110);
        r = $urandom_range(0, 99);
        if (r < 60)      rlen = $urandom_range(1, 8);
        else if (r < 90) rlen = $urandom_range(9, 25);
        else             rlen = $urandom_range(26, 40);
        repeat (plen) push_tick(act);
        repeat (rlen) push_tick(!act);
        sent += plen + rlen;
      end
    end
  endtask

  // Receiver: stall pattern cycles through four modes, chosen by stall_cycle[8:7].
  always @(posedge clk_i) begin : watch_events
    gesture_ev_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_events.size() == 0) begin
          note_mismatch($sformatf("unexpected event transaction: code %0d count %0d held %0d",
                                  event_code_o, click_count_o, held_ms_o));
        end else begin
          want = pending_events.pop_front();
          if (event_code_o !== want.code || click_count_o !== want.count ||
              held_ms_o !== want.held || last_of_tick_o !== want.last)
            note_mismatch($sformatf(
              "event mismatch: exp code %0d count %0d held %0d last %0b, got %0d %0d %0d %0b",
              want.code, want.count, want.held, want.last,
              event_code_o, click_count_o, held_ms_o, last_of_tick_o));
        end
      end
      stall_cycle++;
      case (stall_cycle[8:7])
        2'd0: out_stall_i <= 1'b0;
        2'd1: out_stall_i <= ($urandom_range(0, 3) == 0);
        2'd2: out_stall_i <= ($urandom_range(0, 3) != 0);
        default: out_stall_i <= (stall_cycle[2:0] < 3'd3);
      endcase
    end
  end

  initial begin
    gesture_ev_t e;
    cfg_now = make_settings(ACTIVE_LEVEL_RST, DBCLICK_RST, IDLE_RST, LONG_RST,
                            HOLD_CHECK_RST, HOLD_A_RST, HOLD_B_RST);
    // lvl, typed, n, first code, first count, second code
    script[0]  = '{1'b1, 1'b1, 0, EV_PRESS,   8'd0, EV_PRESS};
    script[1]  = '{1'b0, 1'b1, 2, EV_PRESS,   8'd0, EV_CHANGE};
    script[2]  = '{1'b1, 1'b1, 2, EV_RELEASE, 8'd0, EV_CHANGE};
    script[3]  = '{1'b1, 1'b1, 0, EV_PRESS,   8'd0, EV_PRESS};
    script[4]  = '{1'b1, 1'b1, 1, EV_CLICK,   8'd1, EV_PRESS};
    script[5]  = '{1'b1, 1'b0, 0, EV_PRESS,   8'd0, EV_PRESS};
    script[6]  = '{1'b1, 1'b0, 0, EV_PRESS,   8'd0, EV_PRESS};
    script[7]  = '{1'b1, 1'b1, 2, EV_IDLE,    8'd0, EV_CHANGE};
    script[8]  = '{1'b0, 1'b1, 2, EV_PRESS,   8'd0, EV_CHANGE};
    script[9]  = '{1'b1, 1'b1, 2, EV_RELEASE, 8'd0, EV_CHANGE};
    script[10] = '{1'b0, 1'b0, 0, EV_PRESS,   8'd0, EV_PRESS};
    script[11] = '{1'b1, 1'b0, 0, EV_PRESS,   8'd0, EV_PRESS};
    script[12] = '{1'b1, 1'b0, 0, EV_PRESS,   8'd0, EV_PRESS};
    script[13] = '{1'b1, 1'b1, 1, EV_CLICK,   8'd2, EV_PRESS};
    script[14] = '{1'b1, 1'b0, 0, EV_PRESS,   8'd0, EV_PRESS};
    script[15] = '{1'b1, 1'b0, 0, EV_PRESS,   8'd0, EV_PRESS};
    script[16] = '{1'b1, 1'b1, 2, EV_IDLE,    8'd0, EV_CHANGE};
    script[17] = '{1'b0, 1'b0, 0, EV_PRESS,   8'd0, EV_PRESS};
    script[18] = '{1'b0, 1'b0, 0, EV_PRESS,   8'd0, EV_PRESS};
    script[19] = '{1'b0, 1'b0, 0, EV_PRESS,   8'd0, EV_PRESS};
    script[20] = '{1'b0, 1'b0, 0, EV_PRESS,   8'd0, EV_PRESS};
    script[21] = '{1'b1, 1'b0, 0, EV_PRESS,   8'd0, EV_PRESS};
    script[22] = '{1'b1, 1'b0, 0, EV_PRESS,   8'd0, EV_PRESS};
    script[23] = '{1'b1, 1'b0, 0, EV_PRESS,   8'd0, EV_PRESS};
    script[24] = '{1'b0, 1'b0, 0, EV_PRESS,   8'd0, EV_PRESS};
    script[25] = '{1'b1, 1'b0, 0, EV_PRESS,   8'd0, EV_PRESS};
    script[26] = '{1'b1, 1'b0, 0, EV_PRESS,   8'd0, EV_PRESS};
    script[27] = '{1'b1, 1'b1, 1, EV_CLICK,   8'd1, EV_PRESS};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Short timers: single click, double click, long press swallowing the
    // click, press while the idle wait runs.
    load_settings(make_settings(1'b0, 2, 5, 3, 50, 0, 0));
    foreach (script[i]) begin
      use_typed = script[i].typed;
      typed_evs.delete();
      if (script[i].n >= 1) begin
        e = '{script[i].c0, script[i].k0, 16'd0, 1'b0};
        typed_evs.push_back(e);
      end
      if (script[i].n >= 2) begin
        e = '{script[i].c1, 8'd0, 16'd0, 1'b0};
        typed_evs.push_back(e);
      end
      if (typed_evs.size() > 0) typed_evs[typed_evs.size() - 1].last = 1'b1;
      push_tick(script[i].lvl);
    end
    use_typed = 1'b0;
    settle();

    // zero-length timers, hold period below the floor, active-high pin
    load_settings(make_settings(1'b1, 0, 0, 1, 0, 1, 65535));
    run_gestures(50);
    settle();

    load_settings(make_settings(1'b0, 6, 4, 40, 50, 50, 100));
    run_gestures(60);
    settle();

    // long, hold a and hold b all due at the same check: a release there
    // gives five events in one tick
    load_settings(make_settings(1'b0, 3, 65535, 50, 50, 50, 50));
    run_gestures(50);
    settle();

    // click counting: rapid presses inside a wide window
    load_settings(make_settings(1'b1, 65535, 1, 65535, 65535, 0, 0));
    for (int i = 0; i < 20; i++) push_tick((i % 2) == 1);
    settle();
    load_settings(make_settings(1'b1, 1, 1, 65535, 65535, 0, 0));
    repeat (5) push_tick(1'b0);
    settle();

    if (mismatches == 0 && pending_events.size() == 0) begin
      $display("button_gesture_detector regression: pass");
    end else begin
      $display("button_gesture_detector regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/bgd_pkg.sv
sv/bgd_core.sv
sv/bgd_queue.sv
sv/button_gesture_detector.sv
bench/testbench.sv
